@@ sv/w3zp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3zp_pkg
// Shared types and constants of the 3x3 zero-padded window block.
// ----------------------------------------------------------------------------
package w3zp_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 11;                   // config dimension fields
  localparam int COL_W       = $clog2(MAX_WIDTH);    // line store address
  localparam int ROW_W       = $clog2(MAX_HEIGHT);   // centre row counter
  localparam int CFG_IDX_W   = 2;
  localparam int CH_SEL_W    = 2;
  localparam int WIN_TAPS    = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd2;

  // channel select codes
  localparam logic [CH_SEL_W-1:0] CH_SEL_1 = 2'd1;
  localparam logic [CH_SEL_W-1:0] CH_SEL_2 = 2'd2;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // one classified item, front to back
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] idx;
    logic             emit;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             last;
  } op_t;

  typedef struct packed {
    logic              not_empty;
    logic              full;
    logic [QLVL_W-1:0] level;
  } q_status_t;

endpackage

@@ sv/w3zp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3zp_front
// Config registers, frame position counters and item classification.
// ----------------------------------------------------------------------------
module w3zp_front
  import w3zp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [PIX_W-1:0]     in_ch0,
  input  logic [PIX_W-1:0]     in_ch1,
  input  logic [PIX_W-1:0]     in_ch2,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 restart,
  output logic                 push,
  output op_t                  op
);

  logic [DIM_W-1:0]    width_r, width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic [CH_SEL_W-1:0] chan_r, chan_nxt;
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [DIM_W-1:0]    in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;

  logic accept, in_image, drop, emit;
  logic col_wrap, out_col_wrap;
  logic top, bottom, left, right, last;
  logic [PIX_W-1:0] pix;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_image = in_row_r < height_r;
  assign drop     = (cmd_t'(in_cmd) == CMD_FLUSH) && in_image;
  assign push     = accept && !drop;

  assign restart  = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                  cfg_index == REG_CHANNEL);

  always_comb begin
    case (chan_r)
      CH_SEL_1: pix = in_ch1;
      CH_SEL_2: pix = in_ch2;
      default:  pix = in_ch0;
    endcase
    if (!in_image) pix = '0;
  end

  assign emit         = (in_row_r >= DIM_W'(2)) || (in_row_r == DIM_W'(1) && in_col_r != '0);
  assign col_wrap     = (DIM_W'(in_col_r) + DIM_W'(1)) >= width_r;
  assign out_col_wrap = (DIM_W'(out_col_r) + DIM_W'(1)) >= width_r;
  assign top          = out_row_r == '0;
  assign bottom       = DIM_W'(out_row_r) == (height_r - DIM_W'(1));
  assign left         = out_col_r == '0;
  assign right        = DIM_W'(out_col_r) == (width_r - DIM_W'(1));
  assign last         = bottom && right;

  assign op = '{pix: pix, idx: in_col_r, emit: emit, top: top, bottom: bottom,
                left: left, right: right, last: last};

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    chan_nxt    = chan_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:   width_nxt  = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        REG_HEIGHT:  height_nxt = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        REG_CHANNEL: chan_nxt   = cfg_data[CH_SEL_W-1:0];
        default: ;
      endcase
    end
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (push) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + DIM_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
      chan_r    <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      chan_r    <= chan_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

@@ sv/w3zp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3zp_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module w3zp_queue
  import w3zp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head_op,
  output q_status_t status
);

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_op = slot_r[rd_ptr_r];
  assign status  = '{not_empty: level_r != '0,
                     full:      level_r == QLVL_W'(QUEUE_DEPTH),
                     level:     level_r};

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) level_nxt = level_r + QLVL_W'(1);
    else if (pop && !push) level_nxt = level_r - QLVL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

@@ sv/w3zp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3zp_back
// Line stores, 3x3 shift window, border masking and output register.
// ----------------------------------------------------------------------------
module w3zp_back
  import w3zp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic                      q_valid,
  input  op_t                       q_op,
  output logic                      q_pop,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [WIN_TAPS*PIX_W-1:0] out_data,
  output logic                      out_last
);

  logic [PIX_W-1:0] line_a [MAX_WIDTH];   // row above current
  logic [PIX_W-1:0] line_b [MAX_WIDTH];   // two rows above

  logic             e_valid_r;
  op_t              e_op_r;
  logic [PIX_W-1:0] rd_a_r, rd_b_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_a_r, fwd_b_r;

  logic [2:0][2:0][PIX_W-1:0]  win_r, win_nxt;      // [column][row]
  logic [WIN_TAPS-1:0][PIX_W-1:0] out_data_r, out_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_last_r;

  logic             e_go;
  logic [PIX_W-1:0] up_v, mid_v;

  // same-address write in the cycle of the read: take the written values
  assign up_v  = fwd_r ? fwd_b_r : rd_b_r;
  assign mid_v = fwd_r ? fwd_a_r : rd_a_r;

  assign e_go  = e_valid_r && (!e_op_r.emit || !out_valid_r || out_ready);
  assign q_pop = q_valid && (!e_valid_r || e_go);

  always_comb begin
    win_nxt[0]    = win_r[1];
    win_nxt[1]    = win_r[2];
    win_nxt[2][0] = up_v;
    win_nxt[2][1] = mid_v;
    win_nxt[2][2] = e_op_r.pix;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && e_op_r.top) || (r == 2 && e_op_r.bottom) ||
            (c == 0 && e_op_r.left) || (c == 2 && e_op_r.right)) begin
          out_data_nxt[c*3+r] = '0;
        end else begin
          out_data_nxt[c*3+r] = win_nxt[c][r];
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (e_go && e_op_r.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // line stores and execute-stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_a_r  <= line_a[q_op.idx];
      rd_b_r  <= line_b[q_op.idx];
      e_op_r  <= q_op;
      fwd_a_r <= e_op_r.pix;
      fwd_b_r <= mid_v;
    end
    if (e_go) begin
      line_a[e_op_r.idx] <= e_op_r.pix;
      line_b[e_op_r.idx] <= mid_v;
    end
    if (e_go && e_op_r.emit) begin
      out_data_r <= out_data_nxt;
      out_last_r <= e_op_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      if (q_pop) begin
        e_valid_r <= 1'b1;
        fwd_r     <= e_go && (e_op_r.idx == q_op.idx);
      end else if (e_go) begin
        e_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      if (restart) win_r <= '0;
      else if (e_go) win_r <= win_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

@@ sv/window_3x3_zero_pad_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_3x3_zero_pad_top
// 3x3 neighbourhood of one colour channel, zero padded at all borders.
// Path: queue, execute stage, output register to out_tvalid; window for a pixel
//   appears on the beat width+1 items later (flush beats push the tail out).
// Throughput: one beat per cycle while out_tready is high, set by the single read
//   and write port of each line store, used once per item in the execute stage.
// Reset: synchronous on rst_n low; width 640, height 480, channel 0, frame
//   counters and window zero. Line stores are not cleared.
// ----------------------------------------------------------------------------
module window_3x3_zero_pad_top
  import w3zp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [3*PIX_W-1:0]        in_tdata,   // channel_0, channel_1, channel_2
  input  logic [0:0]                in_tuser,   // cmd: 0 pixel, 1 flush
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [WIN_TAPS*PIX_W-1:0] out_tdata,  // up_left, mid_left, down_left,
                                                // up_centre, centre, down_centre,
                                                // up_right, mid_right, down_right
  output logic                      out_tlast,  // frame_last
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,  // 0 width, 1 height, 2 channel
  input  logic [DIM_W-1:0]          cfg_data
);

  // Front: classifies every beat (pixel, flush, ignored flush), tracks the
  // input and centre positions and works out the border flags.
  // Queue: two-entry buffer so the front keeps taking beats, until it fills,
  // while the result side stalls.
  // Back: line store read, shift window, masking and output register.

  logic      restart;
  logic      q_push, q_pop;
  op_t       push_op, head_op;
  q_status_t q_stat;

  // the user must issue config writes only while the block is idle; not enforced here
  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;

  w3zp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_ch0    (in_tdata[PIX_W-1:0]),
    .in_ch1    (in_tdata[2*PIX_W-1:PIX_W]),
    .in_ch2    (in_tdata[3*PIX_W-1:2*PIX_W]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .push      (q_push),
    .op        (push_op)
  );

  w3zp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .status  (q_stat)
  );

  w3zp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .q_valid   (q_stat.not_empty),
    .q_op      (head_op),
    .q_pop     (q_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  // queue occupancy never exceeds its depth
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QLVL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // no beat lands in a full queue
  a_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |-> !q_stat.full)
    else $error("push into full queue");

  // back only draws from a queue holding an item
  a_q_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

endmodule

@@ bench/window_3x3_zero_pad_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_3x3_zero_pad_top_test
// Self-checking bench for the zero-padded 3x3 window block.
// A queue of beats feeds a bursty sender; a monitor predicts each window from
// every accepted input beat and checks the result stream field by field,
// while the receiver stalls on a rotating pattern. Frame sizes, channel select
// and saturation of the size registers are swept between idle phases.
// ----------------------------------------------------------------------------
module window_3x3_zero_pad_top_test;
  import w3zp_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int PIPE_PAD       = 8;     // cycles allowed for beats still in flight
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int RANDOM_PIXELS  = 650;

  // index 3 is not decoded by the block; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one input beat: tuser carries cmd, tdata carries channel_0 lowest
  typedef struct packed {
    cmd_t             cmd;
    logic [PIX_W-1:0] c2;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c0;
  } beat_t;

  // one window: taps in output order, tap k at bits k*8 upwards
  typedef struct packed {
    logic                      last;
    logic [WIN_TAPS*PIX_W-1:0] taps;
  } window_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [3*PIX_W-1:0]        in_tdata = '0;
  logic [0:0]                in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [WIN_TAPS*PIX_W-1:0] out_tdata;
  logic                      out_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_WIDTH;
  logic [DIM_W-1:0]          cfg_data = '0;

  window_3x3_zero_pad_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  beat_t   beats_to_send [$];
  window_t pending_windows [$];
  int      errors = 0;
  int      pixels_sent = 0;
  int      quiet_cycles = 0;

  // sender / receiver pacing
  bit          beat_taken = 1'b0;  // set at the edge that accepts, cleared by the sender
  bit          no_idle = 1'b0;     // phase runs flat out on both sides
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          stall_run = 0;

  string tap_name [WIN_TAPS] = '{"up_left", "mid_left", "down_left",
                                 "up_centre", "centre", "down_centre",
                                 "up_right", "mid_right", "down_right"};

  // --------------------------------------------------------------------------
  // Window predictor: own copy of the registers, line stores and counters
  // --------------------------------------------------------------------------
  int unsigned         dim_w, dim_h;         // sizes after saturation
  logic [CH_SEL_W-1:0] ch_sel;
  logic [PIX_W-1:0]    line_up  [MAX_WIDTH]; // row two above the input
  logic [PIX_W-1:0]    line_mid [MAX_WIDTH]; // row just above the input
  logic [PIX_W-1:0]    win [3][3];           // [column left..right][row up..down]
  int unsigned         in_col, in_row, out_col, out_row;

  function automatic int unsigned sat_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        win[c][r] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic reset_model();
    dim_w  = 32'(RST_WIDTH);
    dim_h  = 32'(RST_HEIGHT);
    ch_sel = '0;
    // never observable: every read of an unwritten entry lands on the top border
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    restart_frame();
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    case (idx)
      REG_WIDTH:   dim_w = sat_dim(v, MAX_WIDTH);
      REG_HEIGHT:  dim_h = sat_dim(v, MAX_HEIGHT);
      REG_CHANNEL: ch_sel = v[CH_SEL_W-1:0];
      default:     return;  // unused index leaves the frame running
    endcase
    restart_frame();
  endtask

  task automatic predict_window(input beat_t b);
    bit               in_img, emit, at_top, at_bottom, at_left, at_right, at_end;
    logic [PIX_W-1:0] pix, upv, midv, tap;
    window_t          w_exp;

    in_img = in_row < dim_h;
    // flush while the frame still wants pixels: dropped without a trace
    if (b.cmd == CMD_FLUSH && in_img) return;

    // past the image every beat acts as a flush and shifts in zero
    pix = '0;
    if (in_img) begin
      case (ch_sel)
        CH_SEL_1: pix = b.c1;
        CH_SEL_2: pix = b.c2;
        default:  pix = b.c0;  // also covers select 3
      endcase
    end

    upv  = line_up[in_col];
    midv = line_mid[in_col];
    line_up[in_col]  = midv;
    line_mid[in_col] = pix;

    for (int c = 0; c < 2; c++)
      for (int r = 0; r < 3; r++)
        win[c][r] = win[c+1][r];
    win[2][0] = upv;
    win[2][1] = midv;
    win[2][2] = pix;

    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);

    in_col++;
    if (in_col >= dim_w) begin
      in_col = 0;
      in_row++;
    end

    if (!emit) return;

    at_top    = out_row == 0;
    at_bottom = out_row == dim_h - 1;
    at_left   = out_col == 0;
    at_right  = out_col == dim_w - 1;
    at_end    = at_bottom && at_right;

    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        tap = win[c][r];
        if ((r == 0 && at_top) || (r == 2 && at_bottom) ||
            (c == 0 && at_left) || (c == 2 && at_right))
          tap = '0;
        w_exp.taps[(c*3+r)*PIX_W +: PIX_W] = tap;
      end
    end
    w_exp.last = at_end;
    pending_windows = {pending_windows, w_exp};

    // after the frame's final window the next beat opens a new frame
    if (at_end) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= dim_w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps; drives at the falling edge.
  // valid gets one assignment per edge, so back-to-back beats stay high.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    beat_t nxt;
    logic  nv;
    nv = in_tvalid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || beat_taken) begin
      nv = 1'b0;
      beat_taken = 1'b0;
      if (gap_left > 0 && !no_idle) begin
        gap_left--;
      end else if (beats_to_send.size() > 0) begin
        nxt = beats_to_send.pop_front();
        nv = 1'b1;
        in_tdata <= {nxt.c2, nxt.c1, nxt.c0};
        in_tuser <= nxt.cmd;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_tvalid <= nv;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a rotating 16-bit pattern, reloaded whenever stall_run
  // runs out; bit 0 is forced so no stall outlasts a rotation by much.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (stall_run == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      stall_run = 64;
    end
    stall_run--;
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    out_tready <= no_idle || stall_pat[0];
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the result beat first (it cannot depend on the input
  // accepted at the same edge), then predicts from the accepted input beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    window_t w_exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_windows.size() == 0) begin
        $error("window beat with no expectation waiting");
        errors++;
      end else begin
        w_exp = pending_windows.pop_front();
        for (int k = 0; k < WIN_TAPS; k++) begin
          if (out_tdata[k*PIX_W +: PIX_W] !== w_exp.taps[k*PIX_W +: PIX_W]) begin
            $error("%s: expected %0d, got %0d", tap_name[k],
                   w_exp.taps[k*PIX_W +: PIX_W], out_tdata[k*PIX_W +: PIX_W]);
            errors++;
          end
        end
        if (out_tlast !== w_exp.last) begin
          $error("frame_last: expected %0d, got %0d", w_exp.last, out_tlast);
          errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_window(beat_t'({in_tuser[0], in_tdata}));
      beat_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake on any channel ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push(input cmd_t cmd, input logic [PIX_W-1:0] c0, c1, c2);
    beat_t b;
    b.cmd = cmd;
    b.c0  = c0;
    b.c1  = c1;
    b.c2  = c2;
    beats_to_send = {beats_to_send, b};
  endtask

  task automatic push_random(input cmd_t cmd);
    push(cmd, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
         PIX_W'($urandom_range(0, 255)));
  endtask

  // wait until every beat is sent and every window is in, then let the pipe empty
  task automatic settle();
    do @(posedge clk);
    while (beats_to_send.size() != 0 || in_tvalid || pending_windows.size() != 0);
    repeat (PIPE_PAD) @(posedge clk);
  endtask

  // register writes are made only with the block idle, after reset or settle()
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    apply_reg(idx, value[DIM_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame at the current sizes; a broken one stops part way through
  task automatic gen_frame(input bit broken);
    int unsigned npix, cut, pause_at;
    npix     = dim_w * dim_h;
    cut      = broken ? $urandom_range(0, npix - 1) : npix;
    pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, npix - 1) : npix + 1;
    for (int unsigned p = 0; p < cut; p++) begin
      if (p == pause_at) settle();
      if ($urandom_range(0, 24) == 0) push_random(CMD_FLUSH);  // dropped inside image
      push_random(CMD_PIXEL);
    end
    pixels_sent += int'(cut);
    if (!broken) begin
      // width + 1 tail beats; a stray pixel here only counts as a flush
      for (int unsigned i = 0; i <= dim_w; i++)
        push_random(($urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_FLUSH);
      pixels_sent += int'(dim_w) + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit          need_restart;
    int unsigned value, n_frames;
    logic [CFG_IDX_W-1:0] idx;

    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: 3x2 frame, channel 0, extremes of the bytes
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_CHANNEL, 0);
    push(CMD_PIXEL, 8'hFF, 8'h00, 8'h00);
    push(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF);
    push(CMD_FLUSH, 8'hAA, 8'h55, 8'hAA);  // flush inside the image: ignored
    push(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    // sender pauses mid-frame; a write to the unused index must not restart
    settle();
    write_reg(REG_UNUSED, 11'h7FF);
    push(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push(CMD_PIXEL, 8'h80, 8'h7F, 8'h01);
    push(CMD_PIXEL, 8'hFE, 8'h01, 8'h80);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push(CMD_PIXEL, 8'h12, 8'h34, 8'h56);  // pixel past the image acts as flush
    push(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();

    // zero sizes saturate to a single pixel; select 3 falls back to channel 0
    write_reg(REG_CHANNEL, 3);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    push(CMD_PIXEL, 8'h55, 8'hAA, 8'h33);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // 2x2, channel 1 reached through the low bits of a wider value
    write_reg(REG_CHANNEL, 11'h401);
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 2);
    push(CMD_FLUSH, 8'h01, 8'h02, 8'h03);
    push(CMD_PIXEL, 8'h01, 8'hF0, 8'h0F);
    push(CMD_PIXEL, 8'h02, 8'h0F, 8'hF0);
    push(CMD_PIXEL, 8'h03, 8'hC3, 8'h3C);
    push(CMD_PIXEL, 8'h04, 8'h3C, 8'hC3);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();

    // random phases: mostly whole small frames, back to back, some cut short
    need_restart = 1'b0;
    while (pixels_sent < RANDOM_PIXELS) begin
      settle();
      no_idle = ($urandom_range(0, 4) == 0);
      value = $urandom_range(0, 3);
      if (need_restart && value == 0) value = 1;
      repeat (value) begin
        idx = CFG_IDX_W'($urandom_range(0, 2));
        case (idx)
          REG_WIDTH: begin
            case ($urandom_range(0, 9))
              0:       value = 0;
              1:       value = 1;
              9:       value = $urandom_range(13, 40);
              default: value = $urandom_range(2, 12);
            endcase
          end
          REG_HEIGHT: begin
            case ($urandom_range(0, 7))
              0:       value = 0;
              1:       value = 1;
              default: value = $urandom_range(2, 6);
            endcase
          end
          default: value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 3);
        endcase
        write_reg(idx, value);
      end
      // reset sizes are far too big for the random part
      if (dim_w * dim_h > 600) begin
        write_reg(REG_WIDTH, $urandom_range(1, 12));
        write_reg(REG_HEIGHT, $urandom_range(1, 6));
      end
      need_restart = 1'b0;
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        if (f == n_frames - 1 && $urandom_range(0, 7) == 0) begin
          gen_frame(1'b1);
          need_restart = 1'b1;  // counters are mid-frame: next phase rewrites
        end else begin
          gen_frame(1'b0);
        end
      end
    end

    no_idle = 1'b0;

    // settle() waits for the last window and then the pipe latency
    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
